>>> design/mcftd_pkg.sv
// shared constants, payload types and command format for the motor command block
package mcftd_pkg;

  // motor and frame geometry
  localparam int MOTOR_COUNT  = 12;
  localparam int FRAME_LENGTH = 15;
  localparam int MIDX_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int FB_IDX_W     = $clog2(FRAME_LENGTH);

  // field widths
  localparam int IDX_W    = 4;
  localparam int DUTY_W   = 16;
  localparam int TICK_W   = 32;
  localparam int CENTER_W = 14;
  localparam int COUNT_W  = 5;
  localparam int SPEED_W  = 16;
  localparam int MOTOR_W  = 8;

  localparam logic [CENTER_W-1:0] CENTER_RESET = CENTER_W'(2000);
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = COUNT_W'(31);
  localparam logic [7:0]          DELIM        = 8'h23;
  localparam logic [7:0]          ZERO_CHAR    = 8'h30;

  // queue depths, powers of two
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int RES_DEPTH  = 2;
  localparam int RES_AW     = $clog2(RES_DEPTH);

  // input modes
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_EOF  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // frame status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_NONE  = 3'd0;
  localparam status_t ST_OK    = 3'd1;
  localparam status_t ST_DELIM = 3'd2;
  localparam status_t ST_LEN   = 3'd3;
  localparam status_t ST_MOTOR = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  motor_index;
    logic [DUTY_W-1:0] forward_duty;
    logic [DUTY_W-1:0] reverse_duty;
    status_t           frame_status;
    logic              last;
  } out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               tick;
    logic               write;
    logic [MIDX_W-1:0]  motor;
    logic [SPEED_W-1:0] speed;
    logic [TICK_W-1:0]  run;
    status_t            status;
  } cmd_t;

endpackage

>>> design/mcftd_front.sv
// front end: frame buffer, byte counter and frame check, emits one command per item
module mcftd_front import mcftd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  item,
  output logic full,
  output logic q_push,
  output cmd_t q_data,
  input  logic q_full
);

  logic [7:0]         frame_bytes [FRAME_LENGTH];
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         digit [FRAME_LENGTH];
  logic               accept;
  logic               delim_ok;
  logic [MOTOR_W-1:0] motor;
  logic [SPEED_W-1:0] speed;
  logic [TICK_W-1:0]  run;
  status_t            eof_status;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  always_comb begin
    for (int i = 0; i < FRAME_LENGTH; i++) begin
      digit[i] = frame_bytes[i] - ZERO_CHAR;
    end
  end

  // digit arithmetic wraps to 8, 16 and 32 bits
  assign motor = MOTOR_W'(MOTOR_W'(digit[1] * 8'd10) + digit[2]);
  assign speed = SPEED_W'(SPEED_W'(digit[4]) * 16'd1000 + SPEED_W'(digit[5]) * 16'd100
                          + SPEED_W'(digit[6]) * 16'd10 + SPEED_W'(digit[7]));
  assign run   = TICK_W'(digit[9]) * 32'd10000 + TICK_W'(digit[10]) * 32'd1000
                 + TICK_W'(digit[11]) * 32'd100 + TICK_W'(digit[12]) * 32'd10
                 + TICK_W'(digit[13]);

  assign delim_ok = (frame_bytes[0] == DELIM) && (frame_bytes[3] == DELIM)
                    && (frame_bytes[8] == DELIM) && (frame_bytes[14] == DELIM);

  always_comb begin
    priority if (!delim_ok) begin
      eof_status = ST_DELIM;
    end else if (byte_count != COUNT_W'(FRAME_LENGTH)) begin
      eof_status = ST_LEN;
    end else if (motor == '0 || motor > MOTOR_W'(MOTOR_COUNT)) begin
      eof_status = ST_MOTOR;
    end else begin
      eof_status = ST_OK;
    end
  end

  always_comb begin
    q_data        = '0;
    q_data.tick   = (item.mode == MODE_TICK);
    q_data.write  = (item.mode == MODE_EOF) && (eof_status == ST_OK);
    q_data.motor  = MIDX_W'(motor - MOTOR_W'(1));
    q_data.speed  = speed;
    q_data.run    = run;
    q_data.status = (item.mode == MODE_EOF) ? eof_status : ST_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      for (int i = 0; i < FRAME_LENGTH; i++) begin
        frame_bytes[i] <= '0;
      end
    end else if (accept) begin
      if (item.mode == MODE_BYTE) begin
        if (byte_count < COUNT_W'(FRAME_LENGTH)) begin
          frame_bytes[byte_count[FB_IDX_W-1:0]] <= item.data_byte;
        end
        if (byte_count < COUNT_MAX) begin
          byte_count <= byte_count + COUNT_W'(1);
        end
      end else if (item.mode == MODE_EOF) begin
        byte_count <= '0;
      end
    end
  end

endmodule

>>> design/mcftd_cmd_queue.sv
// short command queue between front and back
module mcftd_cmd_queue import mcftd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rdata
);

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + CMDQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (CMDQ_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (CMDQ_AW + 1)'(1);
      end
    end
  end

endmodule

>>> design/mcftd_back.sv
// back end: motor state, timeout sweep and result queue
module mcftd_back import mcftd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  cmd_t                q_data,
  output logic                q_pop,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CENTER_W-1:0] cfg_data,
  output logic                empty,
  input  logic                pop,
  output out_t                result
);

  typedef enum logic {IDLE, SWEEP} state_t;

  state_t              state;
  logic [MIDX_W-1:0]   k;
  status_t             status_r;
  logic [CENTER_W-1:0] center_speed;
  logic [TICK_W-1:0]   tick_count;
  logic [TICK_W-1:0]   start_tick    [MOTOR_COUNT];
  logic [TICK_W-1:0]   run_ticks     [MOTOR_COUNT];
  logic [DUTY_W-1:0]   forward_value [MOTOR_COUNT];
  logic [DUTY_W-1:0]   reverse_value [MOTOR_COUNT];

  out_t                res_mem [RES_DEPTH];
  logic [RES_AW-1:0]   res_wr;
  logic [RES_AW-1:0]   res_rd;
  logic [RES_AW:0]     res_count;

  logic [TICK_W-1:0]   elapsed;
  logic                expired;
  logic                res_push;
  logic                res_pop;
  out_t                res_wdata;
  logic                last_k;
  logic [SPEED_W-1:0]  center_ext;

  assign cfg_ready  = 1'b1;
  assign q_pop      = (state == IDLE) && !q_empty;
  assign center_ext = SPEED_W'(center_speed);

  assign elapsed  = tick_count - start_tick[k];
  assign expired  = (elapsed >= run_ticks[k]);
  assign last_k   = (k == MIDX_W'(MOTOR_COUNT - 1));
  assign res_push = (state == SWEEP) && (res_count < (RES_AW + 1)'(RES_DEPTH));
  assign res_pop  = pop && !empty;
  assign empty    = (res_count == '0);
  assign result   = res_mem[res_rd];

  always_comb begin
    res_wdata              = '0;
    res_wdata.motor_index  = IDX_W'(k) + IDX_W'(1);
    res_wdata.forward_duty = expired ? '0 : forward_value[k];
    res_wdata.reverse_duty = expired ? '0 : reverse_value[k];
    res_wdata.frame_status = status_r;
    res_wdata.last         = last_k;
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wr] <= res_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      k            <= '0;
      status_r     <= ST_NONE;
      center_speed <= CENTER_RESET;
      tick_count   <= '0;
      res_wr       <= '0;
      res_rd       <= '0;
      res_count    <= '0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        start_tick[i]    <= '0;
        run_ticks[i]     <= '0;
        forward_value[i] <= '0;
        reverse_value[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        center_speed <= cfg_data;
      end

      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            if (q_data.tick) begin
              tick_count <= tick_count + TICK_W'(1);
            end
            if (q_data.write) begin
              if (q_data.speed < center_ext) begin
                forward_value[q_data.motor] <= '0;
                reverse_value[q_data.motor] <= center_ext - q_data.speed;
              end else if (q_data.speed > center_ext) begin
                forward_value[q_data.motor] <= q_data.speed - center_ext;
                reverse_value[q_data.motor] <= '0;
              end else begin
                forward_value[q_data.motor] <= '0;
                reverse_value[q_data.motor] <= '0;
              end
              run_ticks[q_data.motor]  <= q_data.run;
              start_tick[q_data.motor] <= tick_count;
            end
            status_r <= q_data.status;
            k        <= '0;
            state    <= SWEEP;
          end
        end
        SWEEP: begin
          if (res_push) begin
            if (expired) begin
              forward_value[k] <= '0;
              reverse_value[k] <= '0;
            end
            if (last_k) begin
              state <= IDLE;
            end else begin
              k <= k + MIDX_W'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase

      if (res_push) begin
        res_wr <= res_wr + RES_AW'(1);
      end
      if (res_pop) begin
        res_rd <= res_rd + RES_AW'(1);
      end
      if (res_push && !res_pop) begin
        res_count <= res_count + (RES_AW + 1)'(1);
      end else if (res_pop && !res_push) begin
        res_count <= res_count - (RES_AW + 1)'(1);
      end
    end
  end

  a_sweep_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == SWEEP && state == IDLE) |-> $past(res_push && res_wdata.last))
    else $error("sweep left without emitting the last item");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_count <= (RES_AW + 1)'(RES_DEPTH))
    else $error("result queue overflow");

  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_data.tick) |=> (tick_count == $past(tick_count) + TICK_W'(1)))
    else $error("tick item did not advance tick count");

endmodule

>>> design/motor_command_frame_timed_drive.sv
// top level of the motor command frame receiver with timed drive
//
//  channel   handshake            payload        meaning
//  -------   ------------------   ------------   ---------------------------------
//  input     push / full          item (in_t)    byte, end of frame or timer tick
//  result    pop / empty          result (out_t) one motor duty pair, 12 per item
//  config    cfg_valid/cfg_ready  cfg_data       center speed, one register
//
//  each item produces 12 results, one per cycle while the result queue has room; the
//  back end applies the command in IDLE, then sweeps the motors in SWEEP through
//  the single elapsed-time comparator and takes no new command until the sweep ends
//  the front end accepts the next item as soon as the command queue has room
//  rst is synchronous, active high; all state but the queue storage clears at once, no clearing pass
//  a full result queue stalls the sweep; a full command queue raises full
module motor_command_frame_timed_drive import mcftd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  in_t                 item,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output out_t                result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CENTER_W-1:0] cfg_data
);

  // front to queue
  logic q_push;
  cmd_t q_wdata;
  logic q_full;

  // queue to back
  logic q_pop;
  logic q_empty;
  cmd_t q_rdata;

  // front end: collects the frame and classifies each item into a command
  mcftd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  // decouples item intake from the motor sweep
  mcftd_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // back end: applies commands, times out motors, queues the results
  mcftd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
